// File: sv/crcchk_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and crc update functions for the crc check engine
package crcchk_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_CRC_MODE      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STATUS_TO_END = 2'd1;

  localparam logic [31:0] INIT16 = 32'h0000_6363;
  localparam logic [31:0] INIT32 = 32'hFFFF_FFFF;
  localparam logic [31:0] POLY32 = 32'hEDB8_8320;

  typedef struct packed {
    logic [31:0] crc_value;
    logic        crc_matches;
  } result_t;

  // byte-wise crc_a update, upper half of the result is zero
  function automatic logic [31:0] upd16(input logic [31:0] crc, input logic [7:0] b);
    logic [7:0]  c;
    logic [15:0] r;
    c = b ^ crc[7:0];
    c = c ^ {c[3:0], 4'b0000};
    r = {8'h00, crc[15:8]} ^ {c, 8'h00} ^ {5'b00000, c, 3'b000} ^ {12'h000, c[7:4]};
    return {16'h0000, r};
  endfunction

  // reflected crc32, one byte unrolled into an xor network
  function automatic logic [31:0] upd32(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ POLY32) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [31:0] upd(input logic mode, input logic [31:0] crc,
                                      input logic [7:0] b);
    return mode ? upd32(crc, b) : upd16(crc, b);
  endfunction

endpackage

// File: sv/crc16a_crc32_check_engine.sv
`timescale 1ns / 1ps
// top level of the crc16a / crc32 check engine with its configuration registers
//
//   channel | signals                                         | handshake
//   --------+-------------------------------------------------+--------------------
//   in      | data_byte, last_byte, expected_crc              | in_valid / in_stall
//   out     | crc_value, crc_matches                          | out_valid / out_stall
//   cfg     | cfg_index, cfg_data                             | cfg_valid / cfg_ready
//
// one byte per cycle while in_stall is low; the result of a last byte reaches the output
// through the input register, then the result register
// the crc state loop closes over one byte update, plus the deferred status byte on the last
// reset (rst, synchronous) clears control state and restarts the message
// in_stall rises only when a last byte waits behind a stalled result
// cfg writes complete in the cycle they are presented
module crc16a_crc32_check_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  input  logic [31:0]                      expected_crc,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      crc_value,
  output logic                             crc_matches,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crcchk_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [crcchk_pkg::CfgDataW-1:0]  cfg_data
);
  import crcchk_pkg::*;

  logic    crc_mode;
  logic    status_to_end;
  logic    out_free;
  logic    res_valid;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode      <= 1'b0;
      status_to_end <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CRC_MODE:      crc_mode      <= cfg_data[0];
        CFG_STATUS_TO_END: status_to_end <= cfg_data[0];
        default: ;
      endcase
    end
  end

  crcchk_core u_core (
    .clk           (clk),
    .rst           (rst),
    .crc_mode      (crc_mode),
    .status_to_end (status_to_end),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .expected_crc  (expected_crc),
    .out_free      (out_free),
    .res_valid     (res_valid),
    .res           (res)
  );

  crcchk_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .res_valid   (res_valid),
    .res         (res),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .crc_value   (crc_value),
    .crc_matches (crc_matches)
  );

endmodule

// File: sv/crcchk_core.sv
`timescale 1ns / 1ps
// input register, crc state and the per-byte update datapath
module crcchk_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     crc_mode,
  input  logic                     status_to_end,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               data_byte,
  input  logic                     last_byte,
  input  logic [31:0]              expected_crc,
  input  logic                     out_free,
  output logic                     res_valid,
  output crcchk_pkg::result_t      res
);
  import crcchk_pkg::*;

  logic        v1;
  logic [7:0]  byte1;
  logic        last1;
  logic [31:0] exp1;

  logic [31:0] crc_register;
  logic [7:0]  held_status;
  logic        status_held;
  logic        at_message_start;

  logic        s1_move;
  logic        hold_now;
  logic        feed_held;
  logic [31:0] crc_base;
  logic [31:0] crc_one;
  logic [31:0] crc_two;
  logic        match;

  assign crc_base  = at_message_start ? (crc_mode ? INIT32 : INIT16) : crc_register;
  assign hold_now  = at_message_start && crc_mode && status_to_end && !last1;
  // the held status byte goes in only after the last byte
  assign feed_held = status_held && !at_message_start && last1;
  assign crc_one   = upd(crc_mode, crc_base, byte1);
  assign crc_two   = feed_held ? upd(crc_mode, crc_one, held_status) : crc_one;
  assign match     = crc_mode ? (crc_two == exp1) : (crc_two[15:0] == exp1[15:0]);

  assign res_valid       = v1 && last1;
  assign res.crc_value   = crc_two;
  assign res.crc_matches = match;

  // a byte that yields no result never waits on the output side
  assign s1_move  = v1 && (!last1 || out_free);
  assign in_stall = v1 && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!in_stall) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte1 <= data_byte;
      last1 <= last_byte;
      exp1  <= expected_crc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_held      <= 1'b0;
      at_message_start <= 1'b1;
    end else if (s1_move) begin
      if (hold_now) begin
        status_held      <= 1'b1;
        at_message_start <= 1'b0;
      end else if (last1) begin
        status_held      <= 1'b0;
        at_message_start <= 1'b1;
      end else begin
        if (at_message_start) begin
          status_held <= 1'b0;
        end
        at_message_start <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      if (hold_now) begin
        held_status  <= byte1;
        crc_register <= crc_base;
      end else begin
        crc_register <= crc_two;
      end
    end
  end

  a_held_mid_message: assert property (@(posedge clk) disable iff (rst)
    status_held |-> !at_message_start)
    else $error("held status byte outside a message");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (s1_move && last1) |=> at_message_start)
    else $error("message did not restart after last byte");

  a_hold_no_result: assert property (@(posedge clk) disable iff (rst)
    (s1_move && hold_now) |=> (status_held && !at_message_start))
    else $error("first byte not held");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && last1 && !out_free))
    else $error("input stalled without a blocked result");

endmodule

// File: sv/crcchk_out_reg.sv
`timescale 1ns / 1ps
// result register toward the output channel
module crcchk_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  crcchk_pkg::result_t res,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         crc_value,
  output logic                crc_matches
);
  import crcchk_pkg::*;

  result_t held;

  assign out_free    = !out_valid || !out_stall;
  assign crc_value   = held.crc_value;
  assign crc_matches = held.crc_matches;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      held <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("pending item dropped");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (out_free && res_valid) |=> out_valid)
    else $error("result not loaded");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(held))
    else $error("stalled result changed");

endmodule

// File: tb/sv/crc16a_crc32_check_engine_tb.sv
`timescale 1ns / 1ps
// testbench for the crc16a / crc32 check engine: directed and random frames against a bit-serial crc model
module crc16a_crc32_check_engine_tb;
  import crcchk_pkg::*;

  localparam logic [31:0]        CRCA_POLY    = 32'h0000_8408;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;
  localparam int                 TOTAL_BYTES  = 1750;
  localparam int                 NUM_STEPS    = 30;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [CfgIdxW-1:0] reg_idx;
    logic [31:0]        reg_data;
    logic [7:0]         data;
    logic               last;
    logic [31:0]        rx_crc;
    logic               fixed;
    logic [31:0]        fixed_crc;
    logic               fixed_match;
  } step_row_t;

  typedef struct {
    logic [31:0] crc;
    logic [7:0]  held;
    bit          held_v;
    bit          at_start;
  } frame_state_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          data_byte;
  logic                last_byte;
  logic [31:0]         expected_crc;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [31:0]         crc_value;
  logic                crc_matches;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // crc register contents of the frame in flight, and the two config bits
  frame_state_t frame_q = '{crc: INIT16, held: 8'h00, held_v: 1'b0, at_start: 1'b1};
  logic         crc_mode_q = 1'b0;
  logic         status_to_end_q = 1'b0;

  result_t pending_crcs[$];
  int      fails = 0;
  int      n_bytes = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;

  // check string "123456789" gives the crc_a check value 0xbf05 (upper half of rx ignored)
  step_row_t steps [NUM_STEPS] = '{
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h31, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h32, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h33, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h34, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h35, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h36, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h37, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h38, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h39, 1'b1, 32'hFFFF_BF05, 1'b1, 32'h0000_BF05, 1'b1},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h00, 1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_REG, CFG_CRC_MODE, 32'h0000_0001, 8'h00, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h00, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_REG, CFG_STATUS_TO_END, 32'hFFFF_FFFF, 8'h00, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    // status byte held, fed after the last byte
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'hA5, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'hFF, 1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    // single-byte frame with deferral on: nothing held
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h3C, 1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    // mode drops to 16 bits mid-frame, held byte fed in 16-bit mode
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h81, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h7E, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_REG, CFG_CRC_MODE, 32'hFFFF_FFFE, 8'h00, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_REG, CFG_SPARE_HI, 32'hFFFF_FFFF, 8'h00, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h00, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    // deferral has no effect in 16-bit mode
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h12, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h34, 1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    // deferral cleared mid-frame, applies only from the next frame
    '{ROW_REG, CFG_CRC_MODE, 32'h0000_0001, 8'h00, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h55, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_REG, CFG_STATUS_TO_END, 32'h0000_0000, 8'h00, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'hAA, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h11, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_BYTE, CFG_CRC_MODE, 32'h0, 8'h22, 1'b1, 32'h0, 1'b0, 32'h0, 1'b0}
  };

  crc16a_crc32_check_engine dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .expected_crc (expected_crc),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .crc_value    (crc_value),
    .crc_matches  (crc_matches),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // bit-serial reflected crc, 16-bit mode keeps only the low half of the register
  function automatic logic [31:0] crc_byte(input logic wide, input logic [31:0] c,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = wide ? c : {16'h0000, c[15:0]};
    r[7:0] = r[7:0] ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ (wide ? POLY32 : CRCA_POLY)) : (r >> 1);
    end
    return r;
  endfunction

  // advances the frame by one byte; returns 1 when the byte closes the frame
  function automatic bit frame_step(inout frame_state_t s, input logic [7:0] b,
                                    input logic last, input logic [31:0] rx,
                                    output result_t res);
    res = '0;
    if (s.at_start) begin
      s.crc = crc_mode_q ? INIT32 : INIT16;
      s.held = 8'h00;
      s.held_v = 1'b0;
      s.at_start = 1'b0;
      if (crc_mode_q && status_to_end_q && !last) begin
        s.held = b;
        s.held_v = 1'b1;
        return 1'b0;
      end
    end
    s.crc = crc_byte(crc_mode_q, s.crc, b);
    if (!last) return 1'b0;
    if (s.held_v) begin
      s.crc = crc_byte(crc_mode_q, s.crc, s.held);
      s.held_v = 1'b0;
    end
    s.at_start = 1'b1;
    res.crc_value = s.crc;
    res.crc_matches = crc_mode_q ? (s.crc == rx) : (s.crc[15:0] == rx[15:0]);
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] rx,
                           input bit fixed = 1'b0, input result_t fixed_res = '0);
    result_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    expected_crc <= rx;
    do @(posedge clk); while (in_stall);
    n_bytes++;
    if (frame_step(frame_q, b, last, rx, res)) pending_crcs.push_back(fixed ? fixed_res : res);
  endtask

  // register writes only once the engine has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] wdata);
    in_valid <= 1'b0;
    while (pending_crcs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= wdata;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CRC_MODE: crc_mode_q = wdata[0];
      CFG_STATUS_TO_END: status_to_end_q = wdata[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic write_random_reg();
    int pick;
    pick = $urandom_range(19);
    if (pick < 9) write_reg(CFG_CRC_MODE, $urandom());
    else if (pick < 18) write_reg(CFG_STATUS_TO_END, $urandom());
    else write_reg(pick == 18 ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom());
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_crcs.size() == 0) begin
        $error("crc result with no frame pending: crc_value %h", crc_value);
        fails++;
      end else begin
        want = pending_crcs.pop_front();
        if (crc_value !== want.crc_value) begin
          $error("crc_value: expected %h, got %h", want.crc_value, crc_value);
          fails++;
        end
        if (crc_matches !== want.crc_matches) begin
          $error("crc_matches: expected %b, got %b", want.crc_matches, crc_matches);
          fails++;
        end
      end
    end
  end

  initial begin
    frame_state_t peek;
    result_t      res;
    logic [7:0]   b;
    logic [31:0]  rx;
    int           pick;
    int           msg_len;
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= 8'h00;
    last_byte <= 1'b0;
    expected_crc <= 32'h0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CRC_MODE;
    cfg_data <= 32'h0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_REG) begin
        write_reg(steps[i].reg_idx, steps[i].reg_data);
      end else begin
        send_byte(steps[i].data, steps[i].last, steps[i].rx_crc, steps[i].fixed,
                  {steps[i].fixed_crc, steps[i].fixed_match});
      end
    end

    while (n_bytes < TOTAL_BYTES) begin
      case ((n_bytes * 4) / TOTAL_BYTES)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 56;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 56;
        end
        default: begin
          idle_pct = 9;
          stall_pct = 9;
        end
      endcase
      if ($urandom_range(5) == 0) write_random_reg();
      pick = $urandom_range(99);
      if (pick < 70) msg_len = $urandom_range(6, 1);
      else if (pick < 95) msg_len = $urandom_range(24, 7);
      else msg_len = $urandom_range(64, 25);
      for (int i = 1; i < msg_len; i++) begin
        send_byte($urandom_range(255), 1'b0, $urandom());
        // occasional register change in the middle of a frame
        if ($urandom_range(99) < 2) write_random_reg();
      end
      b = $urandom_range(255);
      peek = frame_q;
      void'(frame_step(peek, b, 1'b1, 32'h0, res));
      pick = $urandom_range(99);
      if (pick < 45) begin
        rx = res.crc_value;
        if (!crc_mode_q && $urandom_range(1)) rx[31:16] = 16'($urandom());
      end else if (pick < 65) begin
        rx = res.crc_value ^ (32'h0000_0001 << $urandom_range(crc_mode_q ? 31 : 15));
      end else begin
        rx = $urandom();
      end
      send_byte(b, 1'b1, rx);
    end

    in_valid <= 1'b0;
    while (pending_crcs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
